### rtl/ipf_pkg.sv
// Shared types, character constants and helpers for the receive-frame parser queue.
// Used by ipf_parser and ipd_frame_parser_queue; depends on nothing else.
`default_nettype none

package ipf_pkg;

   localparam int CONN_W   = 14;   // connection number field
   localparam int LEN_W    = 7;    // payload length / count field
   localparam int BYTE_W   = 8;
   localparam int DIGIT_W  = 3;
   localparam int PREFIX_LEN = 5;

   localparam logic [BYTE_W-1:0] CHR_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHR_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CHR_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CHR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHR_NINE  = 8'h39;

   // header length includes two bytes that are not payload
   localparam logic [CONN_W-1:0] LEN_OVERHEAD = 14'd2;

   localparam logic [DIGIT_W-1:0] PREFIX_END = 3'd4;

   typedef enum logic [4:0] {
      PH_PREFIX  = 5'b00001,
      PH_CONN    = 5'b00010,
      PH_LEN     = 5'b00100,
      PH_PAYLOAD = 5'b01000,
      PH_SKIP    = 5'b10000
   } phase_type;

   typedef enum logic [2:0] {
      PS_IDLE   = 3'b001,
      PS_EMPTY  = 3'b010,
      PS_STREAM = 3'b100
   } pop_state_type;

   // events from the parser to the queue store
   typedef struct packed {
      logic              text_we;
      logic [LEN_W-1:0]  text_index;
      logic [BYTE_W-1:0] text_byte;
      logic              capture_start;
      logic              commit;
      logic [CONN_W-1:0] conn;
      logic [LEN_W-1:0]  size;
   } evt_type;

   typedef struct packed {
      logic [CONN_W-1:0] conn;
      logic [LEN_W-1:0]  size;
   } meta_type;

   // "+IPD," character at a given prefix position
   function automatic logic [BYTE_W-1:0] prefix_char(input logic [DIGIT_W-1:0] pos);
      logic [BYTE_W-1:0] c;
      case (pos)
         3'd0:    c = 8'h2B;
         3'd1:    c = 8'h49;
         3'd2:    c = 8'h50;
         3'd3:    c = 8'h44;
         3'd4:    c = 8'h2C;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // acc * 10 + d, truncated to the field
   function automatic logic [CONN_W-1:0] dec_mac(input logic [CONN_W-1:0] acc,
                                                input logic [3:0] d);
      logic [CONN_W+2:0] t;
      t = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{(CONN_W-1){1'b0}}, d};
      return t[CONN_W-1:0];
   endfunction

endpackage

`default_nettype wire

### rtl/ipf_parser.sv
// Line parser for "+IPD,<conn>,<len>:<payload>" frames; emits text writes,
// capture start and commit events. Depends on ipf_pkg.
`default_nettype none

module ipf_parser #(
   parameter int MAX_TEXT   = 64,
   parameter int MAX_DIGITS = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        byte_valid,
   input  wire logic [ipf_pkg::BYTE_W-1:0]  byte_data,
   output ipf_pkg::evt_type                 evt
);

   localparam logic [ipf_pkg::LEN_W-1:0]   TEXT_CAP  = MAX_TEXT[ipf_pkg::LEN_W-1:0];
   localparam logic [ipf_pkg::DIGIT_W-1:0] DIGIT_CAP = MAX_DIGITS[ipf_pkg::DIGIT_W-1:0];

   ipf_pkg::phase_type               phase_ff, phase_in;
   logic [ipf_pkg::DIGIT_W-1:0]      pos_ff, pos_in;
   logic [ipf_pkg::CONN_W-1:0]       conn_ff, conn_in;
   logic [ipf_pkg::CONN_W-1:0]       len_ff, len_in;
   logic [ipf_pkg::DIGIT_W-1:0]      dig_ff, dig_in;
   logic [ipf_pkg::LEN_W-1:0]        pay_ff, pay_in;

   logic is_digit;
   logic room;

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      conn_in  = conn_ff;
      len_in   = len_ff;
      dig_in   = dig_ff;
      pay_in   = pay_ff;
      evt      = '0;
      evt.text_byte  = byte_data;
      evt.text_index = pay_ff;
      evt.conn       = conn_ff;
      is_digit = byte_data inside {[ipf_pkg::CHR_ZERO:ipf_pkg::CHR_NINE]};
      room     = dig_ff < DIGIT_CAP;
      if (byte_valid) begin
         case (phase_ff)
            ipf_pkg::PH_PREFIX: begin
               if (byte_data == ipf_pkg::prefix_char(pos_ff)) begin
                  if (pos_ff == ipf_pkg::PREFIX_END) begin
                     pos_in   = '0;
                     conn_in  = '0;
                     dig_in   = '0;
                     phase_in = ipf_pkg::PH_CONN;
                  end else begin
                     pos_in = pos_ff + 3'd1;
                  end
               end else if (byte_data == ipf_pkg::CHR_NL) begin
                  pos_in = '0;
               end else begin
                  pos_in   = '0;
                  phase_in = ipf_pkg::PH_SKIP;
               end
            end
            ipf_pkg::PH_CONN: begin
               if (is_digit && room) begin
                  conn_in = ipf_pkg::dec_mac(conn_ff, byte_data[3:0]);
                  dig_in  = dig_ff + 3'd1;
               end else if (byte_data == ipf_pkg::CHR_COMMA && dig_ff != '0) begin
                  len_in   = '0;
                  dig_in   = '0;
                  phase_in = ipf_pkg::PH_LEN;
               end else begin
                  phase_in = (byte_data == ipf_pkg::CHR_NL) ? ipf_pkg::PH_PREFIX
                                                             : ipf_pkg::PH_SKIP;
               end
            end
            ipf_pkg::PH_LEN: begin
               if (is_digit && room) begin
                  len_in = ipf_pkg::dec_mac(len_ff, byte_data[3:0]);
                  dig_in = dig_ff + 3'd1;
               end else if (byte_data == ipf_pkg::CHR_COLON && dig_ff != '0
                            && len_ff > ipf_pkg::LEN_OVERHEAD) begin
                  len_in            = len_ff - ipf_pkg::LEN_OVERHEAD;
                  pay_in            = '0;
                  evt.capture_start = 1'b1;
                  phase_in          = ipf_pkg::PH_PAYLOAD;
               end else begin
                  phase_in = (byte_data == ipf_pkg::CHR_NL) ? ipf_pkg::PH_PREFIX
                                                             : ipf_pkg::PH_SKIP;
               end
            end
            ipf_pkg::PH_PAYLOAD: begin
               // bytes past the text size are counted off but not stored
               if (pay_ff < TEXT_CAP) begin
                  evt.text_we = 1'b1;
                  pay_in      = pay_ff + 7'd1;
               end
               len_in = len_ff - 14'd1;
               if (len_ff == 14'd1) begin
                  evt.commit = 1'b1;
                  evt.size   = pay_in;
                  phase_in   = ipf_pkg::PH_SKIP;
               end
            end
            ipf_pkg::PH_SKIP: begin
               if (byte_data == ipf_pkg::CHR_NL) begin
                  phase_in = ipf_pkg::PH_PREFIX;
                  pos_in   = '0;
               end
            end
            default: begin
               phase_in = ipf_pkg::PH_PREFIX;
               pos_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ipf_pkg::PH_PREFIX;
         pos_ff   <= '0;
         conn_ff  <= '0;
         len_ff   <= '0;
         dig_ff   <= '0;
         pay_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         conn_ff  <= conn_in;
         len_ff   <= len_in;
         dig_ff   <= dig_in;
         pay_ff   <= pay_in;
      end
   end

endmodule

`default_nettype wire

### rtl/ipd_frame_parser_queue.sv
// A received byte gives no result. A pop is accepted and the slot header is read into
// a register in that cycle; the first result passes the text read register and stage A to stage B.
// Throughput: one byte per cycle while no pop is in progress; a pop holds the input through the
// header read and one text-memory read per byte, an empty pop through its empty state.
// Reset (synchronous) clears parser, queue pointers and output stages; the text
// and header memories are not cleared and need no clearing pass.
`default_nettype none

module ipd_frame_parser_queue #(
   parameter int QUEUE_DEPTH = 8,
   parameter int MAX_TEXT    = 64,
   parameter int MAX_DIGITS  = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,   // server_enable
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,     // [7:0] rx_byte
   input  wire logic        req_tuser,     // [0] func
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,     // [13:0] connection, [20:14] message_length,
                                           // [28:21] data_byte, [31:29] zero
   output      logic        rsp_tuser,     // [0] queue_empty
   output      logic        rsp_tlast      // last_byte
);

   localparam int SLOT_W     = $clog2(QUEUE_DEPTH);
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int TXT_W      = $clog2(MAX_TEXT);
   localparam int TEXT_DEPTH = QUEUE_DEPTH << TXT_W;
   localparam int LAST_SLOT_I = QUEUE_DEPTH - 1;
   localparam logic [CNT_W-1:0]  FULL      = QUEUE_DEPTH[CNT_W-1:0];
   localparam logic [SLOT_W-1:0] LAST_SLOT = LAST_SLOT_I[SLOT_W-1:0];

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + 1'b1;
   endfunction

   logic                      enable_ff;
   ipf_pkg::pop_state_type    state_ff, state_in;
   logic [SLOT_W-1:0]         head_ff, head_in;
   logic [SLOT_W-1:0]         tail_ff, tail_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic [TXT_W-1:0]          k_ff, k_in;

   logic [7:0]                text_mem [TEXT_DEPTH];
   ipf_pkg::meta_type         meta_mem [QUEUE_DEPTH];
   ipf_pkg::meta_type         meta_q_ff;
   logic [7:0]                rd_q_ff;

   // stage A is registered alongside the text read register, stage B is the output register
   logic                          a_valid_ff, a_last_ff, a_empty_ff;
   logic [ipf_pkg::CONN_W-1:0]    a_conn_ff;
   logic [ipf_pkg::LEN_W-1:0]     a_len_ff;
   logic                          b_valid_ff, b_last_ff, b_empty_ff;
   logic [ipf_pkg::CONN_W-1:0]    b_conn_ff;
   logic [ipf_pkg::LEN_W-1:0]     b_len_ff;
   logic [7:0]                    b_data_ff;

   ipf_pkg::evt_type          evt;
   logic                      req_xfer, pop_xfer, byte_xfer;
   logic                      advance, issue_text, issue_empty, issue_last;
   logic [ipf_pkg::LEN_W-1:0] k_ext;

   assign req_tready = (state_ff == ipf_pkg::PS_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign pop_xfer   = req_xfer && req_tuser;
   assign byte_xfer  = req_xfer && !req_tuser && enable_ff;

   ipf_parser #(
      .MAX_TEXT   (MAX_TEXT),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_xfer),
      .byte_data  (req_tdata),
      .evt        (evt)
   );

   assign advance     = !b_valid_ff || rsp_tready;
   assign issue_text  = (state_ff == ipf_pkg::PS_STREAM) && advance;
   assign issue_empty = (state_ff == ipf_pkg::PS_EMPTY) && advance;
   assign k_ext       = ipf_pkg::LEN_W'(k_ff);
   assign issue_last  = (k_ext + 7'd1) == meta_q_ff.size;

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      slot_in  = slot_ff;
      k_in     = k_ff;
      if (evt.capture_start && count_ff == FULL) begin
         // oldest message makes room before the new one is written
         head_in  = next_slot(head_ff);
         count_in = count_ff - 1'b1;
      end else if (evt.commit) begin
         tail_in  = next_slot(tail_ff);
         count_in = count_ff + 1'b1;
      end else if (pop_xfer) begin
         if (count_ff == '0) begin
            state_in = ipf_pkg::PS_EMPTY;
         end else begin
            slot_in  = head_ff;
            head_in  = next_slot(head_ff);
            count_in = count_ff - 1'b1;
            k_in     = '0;
            state_in = ipf_pkg::PS_STREAM;
         end
      end
      case (state_ff)
         ipf_pkg::PS_IDLE: ;
         ipf_pkg::PS_EMPTY: begin
            if (advance) state_in = ipf_pkg::PS_IDLE;
         end
         ipf_pkg::PS_STREAM: begin
            if (issue_text) begin
               if (issue_last) state_in = ipf_pkg::PS_IDLE;
               else k_in = k_ff + 1'b1;
            end
         end
         default: state_in = ipf_pkg::PS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         state_ff   <= ipf_pkg::PS_IDLE;
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) enable_ff <= csr_wr_data;
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if (advance) begin
            a_valid_ff <= issue_text || issue_empty;
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      k_ff    <= k_in;
      if (advance) begin
         a_last_ff  <= issue_empty || issue_last;
         a_empty_ff <= issue_empty;
         a_conn_ff  <= issue_empty ? '0 : meta_q_ff.conn;
         a_len_ff   <= issue_empty ? '0 : meta_q_ff.size;
         b_last_ff  <= a_last_ff;
         b_empty_ff <= a_empty_ff;
         b_conn_ff  <= a_conn_ff;
         b_len_ff   <= a_len_ff;
         b_data_ff  <= a_empty_ff ? '0 : rd_q_ff;
      end
   end

   // text store: writes come from byte transfers, reads only while streaming
   always_ff @(posedge clock) begin
      if (evt.text_we) begin
         text_mem[{tail_ff, evt.text_index[TXT_W-1:0]}] <= evt.text_byte;
      end else if (issue_text) begin
         rd_q_ff <= text_mem[{slot_ff, k_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (evt.commit) begin
         meta_mem[tail_ff] <= '{conn: evt.conn, size: evt.size};
      end else if (pop_xfer) begin
         meta_q_ff <= meta_mem[head_ff];
      end
   end

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = {3'b000, b_data_ff, b_len_ff, b_conn_ff};
   assign rsp_tuser  = b_empty_ff;
   assign rsp_tlast  = b_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("queue count beyond depth");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      pop_xfer && count_ff == '0 |=> state_ff == ipf_pkg::PS_EMPTY)
      else $error("pop of empty queue did not report empty");

   a_text_port: assert property (@(posedge clock) disable iff (reset)
      evt.text_we |-> state_ff == ipf_pkg::PS_IDLE)
      else $error("text write during pop stream");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      issue_text |-> k_ext < meta_q_ff.size)
      else $error("text read past stored length");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_empty_ff |-> b_last_ff && b_data_ff == '0 && b_len_ff == '0)
      else $error("empty result malformed");

endmodule

`default_nettype wire
